### rtl/homogeneous_nfa_step_engine_macros.svh
// Assertion macros for the homogeneous NFA step engine.
`ifndef HOMOGENEOUS_NFA_STEP_ENGINE_MACROS_SVH
`define HOMOGENEOUS_NFA_STEP_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge out of reset
`define HNSE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// ante in this cycle implies cons in the next cycle
`define HNSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HNSE_ASSERT_ALWAYS(lbl, expr, msg)
`define HNSE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/hnse_pkg.sv
// Shared types and constants for the homogeneous NFA step engine.
package hnse_pkg;

    localparam int NUM_STATES = 64;
    localparam int IDX_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam logic [63:0] STATE_MASK = {64{1'b1}} >> (64 - NUM_STATES);

    // request modes
    localparam logic [1:0] MODE_SYMBOL   = 2'd0;
    localparam logic [1:0] MODE_MATCH_WR = 2'd1;
    localparam logic [1:0] MODE_SUCC_WR  = 2'b10;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MASK = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  symbol;
        logic [31:0] position;
        logic        begin_segment;
        logic        with_start_states;
        logic [7:0]  table_index;
        logic [63:0] table_word;
    } hnse_req_t;

    typedef struct packed {
        logic [31:0] report_position;
        logic [63:0] report_vector;
    } hnse_res_t;

    // controller -> datapath
    typedef struct packed {
        logic             start_sym;
        logic             wr_match;
        logic             wr_succ;
        logic             calc_match;
        logic             emit;
        logic             sweep_rd;
        logic             finish;
        logic [IDX_W-1:0] sweep_idx;
    } hnse_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic report_nz;
        logic out_free;
    } hnse_stat_t;

endpackage

### rtl/hnse_ctrl.sv
// Sequencer for the homogeneous NFA step engine.
module hnse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_mode,
    output logic                s_ready,
    input  hnse_pkg::hnse_stat_t stat,
    output hnse_pkg::hnse_cmd_t  cmd
);
    import hnse_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MATCH  = 3'd1;
    localparam logic [2:0] ST_EMIT   = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.sweep_idx = cnt_reg;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_mode)
                        MODE_SYMBOL: begin
                            cmd.start_sym = 1'b1;
                            state_next    = ST_MATCH;
                        end
                        MODE_MATCH_WR: cmd.wr_match = 1'b1;
                        MODE_SUCC_WR:  cmd.wr_succ  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_MATCH: begin
                cmd.calc_match = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                // hold here while a report is ready but the output is still full
                if (!stat.report_nz || stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_rd = 1'b1;
                if (cnt_reg == IDX_W'(NUM_STATES - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/hnse_dp.sv
// Datapath: tables, active set, config masks and output register.
module hnse_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hnse_pkg::hnse_cmd_t   cmd,
    output hnse_pkg::hnse_stat_t  stat,
    input  hnse_pkg::hnse_req_t   s_req,
    input  logic                  cfg_valid,
    input  logic [hnse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output hnse_pkg::hnse_res_t   m_res
);
    import hnse_pkg::*;

    logic [63:0] start_mask_reg, always_mask_reg, report_mask_reg;
    logic [63:0] active_reg, active_next;
    logic [63:0] matched_reg, reports_reg, matched_next;
    logic [31:0] position_reg;
    logic [63:0] acc_reg, acc_next, acc_now;

    logic [63:0] match_mem [256];
    logic [63:0] succ_mem  [NUM_STATES];
    logic [63:0] match_rd_reg, succ_rd_reg;
    logic        succ_vld_reg;
    logic [IDX_W-1:0] succ_idx_reg;
    logic        succ_in_range;

    logic        m_valid_reg;
    hnse_res_t   m_res_reg;

    assign succ_in_range = 9'(s_req.table_index) < 9'(NUM_STATES);
    assign matched_next  = active_reg & match_rd_reg & STATE_MASK;
    assign acc_now = acc_reg |
        ((succ_vld_reg && matched_reg[succ_idx_reg]) ? succ_rd_reg : 64'd0);
    assign acc_next = cmd.calc_match ? 64'd0 : acc_now;

    always_comb begin
        active_next = active_reg;
        if (cmd.start_sym && s_req.begin_segment) begin
            active_next = always_mask_reg |
                (s_req.with_start_states ? start_mask_reg : 64'd0);
        end
        if (cmd.finish) begin
            active_next = acc_now | always_mask_reg;
        end
        active_next = active_next & STATE_MASK;
    end

    // match table: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_match) begin
            match_mem[s_req.table_index] <= s_req.table_word;
        end
        if (cmd.start_sym) begin
            match_rd_reg <= match_mem[s_req.symbol];
        end
    end

    // successor table
    always_ff @(posedge aclk) begin
        if (cmd.wr_succ && succ_in_range) begin
            succ_mem[s_req.table_index[IDX_W-1:0]] <= s_req.table_word;
        end
        if (cmd.sweep_rd) begin
            succ_rd_reg <= succ_mem[cmd.sweep_idx];
        end
    end

    always_ff @(posedge aclk) begin
        succ_idx_reg <= cmd.sweep_idx;
        acc_reg      <= acc_next;
        if (cmd.start_sym) begin
            position_reg <= s_req.position;
        end
        if (cmd.calc_match) begin
            matched_reg <= matched_next;
            reports_reg <= matched_next & report_mask_reg;
        end
        // only a real report touches the output payload
        if (cmd.emit && (reports_reg != 64'd0)) begin
            m_res_reg.report_position <= position_reg;
            m_res_reg.report_vector   <= reports_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mask_reg  <= '0;
            always_mask_reg <= '0;
            report_mask_reg <= '0;
            active_reg      <= '0;
            succ_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            active_reg   <= active_next;
            succ_vld_reg <= cmd.sweep_rd;
            if (cmd.emit && (reports_reg != 64'd0)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_START_MASK:  start_mask_reg  <= cfg_data;
                    CFG_ALWAYS_MASK: always_mask_reg <= cfg_data;
                    CFG_REPORT_MASK: report_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign stat.report_nz = (reports_reg != 64'd0);
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_res          = m_res_reg;

endmodule

### rtl/homogeneous_nfa_step_engine.sv
// Homogeneous NFA step engine top level: sequencer plus datapath.
//
// Usage:
//  - s_valid/s_ready/s_req carry requests. mode MODE_MATCH_WR loads a
//    per-symbol match vector, MODE_SUCC_WR loads one successor row; both
//    give no result. Mode 3 is dropped.
//  - A MODE_SYMBOL request runs one NFA step. It occupies the engine from
//    accept to the next accept: a match table read, the report step, then
//    one successor table read per state, swept in order over the single
//    successor memory port, then the active set update.
//  - A non-zero report (matched AND report_mask) goes to the output register
//    m_valid/m_ready/m_res in the report step, after the match calculation.
//  - If the receiver stalls and the output register is still full when the
//    next report is ready, the engine waits in its report cycle until the
//    output frees up; nothing is dropped.
//  - cfg_valid/cfg_index/cfg_data write the three masks; cfg_ready is always
//    high. Write configuration only while the engine is idle.
//  - aresetn (synchronous, active low) clears the masks, the active set and
//    the output valid. Tables are not cleared and must be loaded before use.
`include "homogeneous_nfa_step_engine_macros.svh"

module homogeneous_nfa_step_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hnse_pkg::hnse_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output hnse_pkg::hnse_res_t m_res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [hnse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]         cfg_data
);
    import hnse_pkg::*;

    hnse_cmd_t  cmd;
    hnse_stat_t stat;

    // config writes are registered directly, no back-pressure needed
    assign cfg_ready = 1'b1;

    hnse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_req.mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hnse_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_req     (s_req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (m_res)
    );

    // a result always carries at least one reporting state
    `HNSE_ASSERT_ALWAYS(a_res_nonzero, !m_valid || (m_res.report_vector != 64'd0), "empty report")

    // reports never name states beyond NUM_STATES
    `HNSE_ASSERT_ALWAYS(a_res_in_range, !m_valid || ((m_res.report_vector & ~STATE_MASK) == 64'd0), "report out of range")

    // a symbol step keeps the input closed in the following cycle
    `HNSE_ASSERT_NEXT(a_sym_busy, s_valid && s_ready && (s_req.mode == MODE_SYMBOL), !s_ready, "accepted during step")

endmodule
